>>> rtl/olst_pkg.sv
// Package: shared types and constants for the ordered list store.
`default_nettype none

package olst_pkg;

    localparam logic [2:0] OP_INS_TAIL = 3'd0;
    localparam logic [2:0] OP_INS_HEAD = 3'd1;
    localparam logic [2:0] OP_INS_POS  = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_SEARCH   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [5:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_position;
        logic [5:0] element_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD
    } cell_sel_t;

    typedef struct packed {
        logic      cap_match;
        cell_sel_t sel;
    } cell_ctrl_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_EXEC
    } seq_state_t;

    typedef struct packed {
        logic req_stall;
        logic accept;
        logic exec;
    } seq_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/olst_cell.sv
// One list slot: holds a value, compares it against the probe, shifts with its neighbors.
`default_nettype none

module olst_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire olst_pkg::cell_ctrl_t ctrl,
    input  wire logic signed [31:0]  probe,
    input  wire logic signed [31:0]  key,
    input  wire logic                occupied,
    input  wire logic signed [31:0]  prev_value,
    input  wire logic signed [31:0]  next_value,
    output logic signed [31:0]       value,
    output logic                     match
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        case (ctrl.sel)
            olst_pkg::CELL_FROM_PREV: value_next = prev_value;
            olst_pkg::CELL_FROM_NEXT: value_next = next_value;
            olst_pkg::CELL_LOAD:      value_next = key;
            default:                  value_next = value_reg;
        endcase
    end

    assign match_next = ctrl.cap_match ? (occupied && (value_reg == probe)) : match_reg;

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

>>> rtl/olst_seq.sv
// Sequencer: two-step accept/execute control and input flow control.
`default_nettype none

module olst_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_stall,
    output olst_pkg::seq_ctrl_t  ctrl
);

    olst_pkg::seq_state_t state_reg;
    olst_pkg::seq_state_t state_next;
    logic                 can_take;

    // result slot is free, or is being emptied at this edge
    assign can_take = !(rsp_valid && rsp_stall);

    always_comb
    begin
        case (state_reg)
            olst_pkg::SEQ_IDLE:
                state_next = (req_valid && can_take) ? olst_pkg::SEQ_EXEC : olst_pkg::SEQ_IDLE;
            olst_pkg::SEQ_EXEC:
                state_next = olst_pkg::SEQ_IDLE;
            default:
                state_next = olst_pkg::SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            olst_pkg::SEQ_IDLE:
            begin
                ctrl.req_stall = !can_take;
                ctrl.accept    = can_take && req_valid;
                ctrl.exec      = 1'b0;
            end
            olst_pkg::SEQ_EXEC:
            begin
                ctrl.req_stall = 1'b1;
                ctrl.accept    = 1'b0;
                ctrl.exec      = 1'b1;
            end
            default:
            begin
                ctrl.req_stall = 1'b1;
                ctrl.accept    = 1'b0;
                ctrl.exec      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olst_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ordered_list_store.sv
// Top level: ordered list store built from a chain of value cells.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one operation per transfer:
//   insert at tail, insert at head, insert before a 1-based position,
//   delete first equal value, or search for first equal value.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result per
//   operation: status, found position and element count after the operation.
// Timing:
//   At the request transfer every cell latches its compare against the value.
//   The next cycle resolves the first match / target slot, shifts the chain
//   by one place on an insert or delete and loads the result register;
//   rsp_valid rises together with that load. An operation is made of the
//   compare step and the shift step of the cell chain.
// Reset: list is empty (count 0), no result pending. Slot contents are not
//   cleared; only slots below the count are ever looked at.
// Stall: a pending result holds while rsp_stall is high; a new request is
//   taken once the result slot is free or is emptied in the same cycle.
`default_nettype none

module ordered_list_store #(
    parameter int CAPACITY = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire olst_pkg::req_t   req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output olst_pkg::rsp_t        rsp
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > 6) ? CW : 6;

    olst_pkg::seq_ctrl_t seq;

    logic [2:0]          op_reg;
    logic signed [31:0]  key_reg;
    logic [5:0]          pos_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    olst_pkg::rsp_t      rsp_reg;
    olst_pkg::rsp_t      rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    logic signed [31:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] first_oh;
    logic [CAPACITY-1:0] del_ge;
    logic [CAPACITY-1:0] tgt_oh;
    logic [CAPACITY-1:0] ins_ge;
    logic [IW-1:0]       first_idx;
    logic [IW-1:0]       tgt_idx;
    logic                any_match;
    logic                full;
    logic                ins_do;
    logic                del_do;
    logic [1:0]          status_w;
    logic [CW-1:0]       found_w;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;

    olst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .rsp_valid (rsp_valid_reg),
        .rsp_stall (rsp_stall),
        .ctrl      (seq)
    );

    // first match: lowest set bit of the latched match vector
    assign first_oh  = match_vec & (~match_vec + CAPACITY'(1));
    assign del_ge    = ~(first_oh - CAPACITY'(1));
    assign any_match = |match_vec;

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_oh[i])
            begin
                first_idx = first_idx | IW'(i);
            end
        end
    end

    assign full    = (count_reg == CW'(CAPACITY));
    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        status_w = olst_pkg::ST_MISS;
        found_w  = '0;
        ins_do   = 1'b0;
        del_do   = 1'b0;
        tgt_idx  = '0;
        case (op_reg)
            olst_pkg::OP_INS_TAIL, olst_pkg::OP_INS_HEAD, olst_pkg::OP_INS_POS:
            begin
                if (full)
                begin
                    status_w = olst_pkg::ST_FULL;
                end
                else if (op_reg == olst_pkg::OP_INS_TAIL)
                begin
                    ins_do   = 1'b1;
                    tgt_idx  = IW'(count_reg);
                    status_w = olst_pkg::ST_OK;
                end
                else if (op_reg == olst_pkg::OP_INS_HEAD)
                begin
                    ins_do   = 1'b1;
                    tgt_idx  = '0;
                    status_w = olst_pkg::ST_OK;
                end
                else if ((pos_ext != '0) && (pos_ext <= cnt_ext))
                begin
                    ins_do   = 1'b1;
                    tgt_idx  = IW'(pos_ext - CMP_W'(1));
                    status_w = olst_pkg::ST_OK;
                end
            end
            olst_pkg::OP_DELETE:
            begin
                if (any_match)
                begin
                    del_do   = 1'b1;
                    status_w = olst_pkg::ST_OK;
                end
            end
            olst_pkg::OP_SEARCH:
            begin
                if (any_match)
                begin
                    found_w  = CW'(first_idx) + CW'(1);
                    status_w = olst_pkg::ST_OK;
                end
            end
            default:
            begin
                status_w = olst_pkg::ST_MISS;
            end
        endcase
    end

    assign tgt_oh = CAPACITY'(1) << tgt_idx;
    assign ins_ge = ~(tgt_oh - CAPACITY'(1));

    always_comb
    begin
        count_next = count_reg;
        if (seq.exec && ins_do)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (seq.exec && del_do)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            olst_pkg::cell_ctrl_t cctl;
            logic signed [31:0]   prev_v;
            logic signed [31:0]   next_v;
            logic                 occ;

            always_comb
            begin
                cctl.cap_match = seq.accept;
                if (seq.exec && ins_do && ins_ge[g])
                begin
                    cctl.sel = tgt_oh[g] ? olst_pkg::CELL_LOAD : olst_pkg::CELL_FROM_PREV;
                end
                else if (seq.exec && del_do && del_ge[g])
                begin
                    cctl.sel = olst_pkg::CELL_FROM_NEXT;
                end
                else
                begin
                    cctl.sel = olst_pkg::CELL_HOLD;
                end
            end

            if (g == 0)
            begin : g_head
                assign prev_v = key_reg;
            end
            else
            begin : g_body
                assign prev_v = cell_val[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign next_v = '0;
            end
            else
            begin : g_inner
                assign next_v = cell_val[g+1];
            end

            assign occ = (CW'(g) < count_reg);

            olst_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cctl),
                .probe      (req.value),
                .key        (key_reg),
                .occupied   (occ),
                .prev_value (prev_v),
                .next_value (next_v),
                .value      (cell_val[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_next.status         = status_w;
        rsp_next.found_position = 6'(found_w);
        rsp_next.element_count  = 6'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (seq.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.accept)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.value;
            pos_reg <= req.position;
        end
        if (seq.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = seq.req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> verif/tb_ordered_list_store.sv
// Testbench for ordered_list_store: random and directed list operations checked against a predictor.
`timescale 1ns / 100ps

module tb_ordered_list_store;

    localparam int LIST_CAP = 32;
    localparam int RANDOM_ITEMS = 930;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

    typedef struct {
        olst_pkg::req_t op;
        bit             wait_idle;    // hold this transfer until all results are back
    } list_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    olst_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    olst_pkg::rsp_t rsp;

    list_item_t     pending_ops_q[$];
    olst_pkg::rsp_t expected_rsp_q[$];

    // predicted list contents
    logic [31:0] list_vals [LIST_CAP];
    int          list_cnt = 0;

    logic req_fired = 1'b0;
    int   cycle_cnt = 0;
    int   accepted_cnt = 0;
    int   fail_cnt = 0;

    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode_left = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    int   holds_done = 0;

    ordered_list_store #(.CAPACITY(LIST_CAP)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    function automatic olst_pkg::rsp_t apply_list_op(input olst_pkg::req_t r);
        olst_pkg::rsp_t res;
        int             hit;
        int             ins_at;
        res.status = olst_pkg::ST_MISS;
        res.found_position = '0;
        hit = list_cnt;
        ins_at = -1;
        case (r.opcode)
            olst_pkg::OP_INS_TAIL, olst_pkg::OP_INS_HEAD, olst_pkg::OP_INS_POS:
            begin
                if (list_cnt >= LIST_CAP)
                    res.status = olst_pkg::ST_FULL;
                else if (r.opcode == olst_pkg::OP_INS_TAIL)
                    ins_at = list_cnt;
                else if (r.opcode == olst_pkg::OP_INS_HEAD)
                    ins_at = 0;
                else if (int'(r.position) >= 1 && int'(r.position) <= list_cnt)
                    ins_at = int'(r.position) - 1;
            end
            olst_pkg::OP_DELETE, olst_pkg::OP_SEARCH:
            begin
                for (int i = list_cnt - 1; i >= 0; i--)
                    if (list_vals[i] == r.value)
                        hit = i;
                if (hit < list_cnt)
                begin
                    res.status = olst_pkg::ST_OK;
                    if (r.opcode == olst_pkg::OP_SEARCH)
                        res.found_position = 6'(hit + 1);
                    else
                    begin
                        for (int i = hit; i + 1 < list_cnt; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_cnt--;
                    end
                end
            end
            default:
                ;
        endcase
        if (ins_at >= 0)
        begin
            for (int i = list_cnt; i > ins_at; i--)
                list_vals[i] = list_vals[i - 1];
            list_vals[ins_at] = r.value;
            list_cnt++;
            res.status = olst_pkg::ST_OK;
        end
        res.element_count = 6'(list_cnt);
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [5:0] want,
                                 input logic [5:0] got);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        fail_cnt++;
    endtask

    task automatic add_op(input logic [2:0] opcode, input logic [31:0] val,
                          input logic [5:0] pos, input bit wait_idle);
        list_item_t it;
        it.op.opcode = opcode;
        it.op.value = val;
        it.op.position = pos;
        it.wait_idle = wait_idle;
        pending_ops_q.push_back(it);
    endtask

    // sample both channels; results are checked before new requests are predicted
    always @(posedge clk)
    begin : sample_channels
        olst_pkg::rsp_t want;
        cycle_cnt <= cycle_cnt + 1;
        req_fired <= rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer: expected none, got %p",
                         $time, rsp);
                fail_cnt++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch("status", 6'(want.status), 6'(rsp.status));
                if (rsp.found_position !== want.found_position)
                    note_mismatch("found_position", want.found_position, rsp.found_position);
                if (rsp.element_count !== want.element_count)
                    note_mismatch("element_count", want.element_count, rsp.element_count);
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsp_q.push_back(apply_list_op(req));
            accepted_cnt++;
        end
    end

    // request driver: bursts with random gaps, payload held while stalled
    always @(negedge clk)
    begin : drive_req
        list_item_t     nxt;
        logic           nxt_valid;
        olst_pkg::req_t nxt_req;
        nxt_valid = req_valid;
        nxt_req = req;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (!(req_valid && !req_fired))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops_q.size() != 0 &&
                     !(pending_ops_q[0].wait_idle && expected_rsp_q.size() != 0))
            begin
                nxt = pending_ops_q.pop_front();
                nxt_req = nxt.op;
                nxt_valid = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 19) == 0)
                        gap_left = $urandom_range(15, 40);
                end
                else
                    burst_left--;
            end
        end
        req_valid <= nxt_valid;
        req <= nxt_req;
    end

    // result stall: random duty per stretch, plus two long hold-offs
    always @(negedge clk)
    begin : drive_stall
        logic nxt_stall;
        if (hold_left > 0)
        begin
            hold_left--;
            nxt_stall = 1'b1;
        end
        else if (holds_done < 2 && accepted_cnt >= (holds_done + 1) * 300)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            nxt_stall = 1'b1;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode_left = $urandom_range(10, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            else
                stall_mode_left--;
            nxt_stall = ($urandom_range(0, 99) < stall_pct);
        end
        rsp_stall <= nxt_stall;
    end

    initial
    begin : stimulus
        logic [31:0] value_pool [8];
        logic [31:0] val;
        logic [2:0]  opcode;
        logic [5:0]  pos;
        int          sent;
        int          phase_kind;
        int          phase_len;
        int          roll;
        bit          wait_first;

        // empty list corner cases
        add_op(olst_pkg::OP_SEARCH, 32'd0, 6'd0, 1'b0);
        add_op(olst_pkg::OP_DELETE, 32'd0, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_POS, 32'd9, 6'd1, 1'b0);
        add_op(OP_UNUSED_LAST, 32'd9, 6'd1, 1'b0);
        // single element removed again
        add_op(olst_pkg::OP_INS_TAIL, 32'd5, 6'd0, 1'b0);
        add_op(olst_pkg::OP_DELETE, 32'd5, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_TAIL, 32'h7fff_ffff, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_HEAD, 32'h8000_0000, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_POS, 32'hffff_ffff, 6'd1, 1'b0);
        add_op(olst_pkg::OP_INS_POS, 32'd0, 6'd3, 1'b0);          // position equal to count
        add_op(olst_pkg::OP_INS_POS, 32'd7, 6'd5, 1'b0);          // one past count
        add_op(olst_pkg::OP_INS_POS, 32'd7, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_POS, 32'd7, 6'd63, 1'b0);
        add_op(OP_UNUSED_FIRST, 32'd0, 6'd1, 1'b0);
        add_op(OP_UNUSED_MID, 32'hffff_ffff, 6'd63, 1'b0);
        add_op(olst_pkg::OP_SEARCH, 32'h7fff_ffff, 6'd0, 1'b0);
        add_op(olst_pkg::OP_SEARCH, 32'd12345, 6'd0, 1'b0);
        add_op(olst_pkg::OP_INS_TAIL, 32'hffff_ffff, 6'd0, 1'b0);
        add_op(olst_pkg::OP_SEARCH, 32'hffff_ffff, 6'd0, 1'b0);   // duplicate: first one wins
        add_op(olst_pkg::OP_DELETE, 32'hffff_ffff, 6'd0, 1'b0);
        add_op(olst_pkg::OP_DELETE, 32'd999, 6'd0, 1'b0);
        add_op(olst_pkg::OP_DELETE, 32'h8000_0000, 6'd0, 1'b0);

        value_pool[0] = 32'd0;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7fff_ffff;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();

        // phases biased toward filling, draining or a mix, so the list
        // swings between empty and full
        sent = 0;
        wait_first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            phase_kind = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 70);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                else if ((phase_kind == 0 && roll < 85) || (phase_kind == 1 && roll < 15) ||
                         (phase_kind == 2 && roll < 40))
                begin
                    case ($urandom_range(0, 2))
                        0: opcode = olst_pkg::OP_INS_TAIL;
                        1: opcode = olst_pkg::OP_INS_HEAD;
                        default: opcode = olst_pkg::OP_INS_POS;
                    endcase
                end
                else if ((phase_kind == 0 && roll < 91) || (phase_kind == 1 && roll < 80) ||
                         (phase_kind == 2 && roll < 65))
                    opcode = olst_pkg::OP_DELETE;
                else
                    opcode = olst_pkg::OP_SEARCH;

                if ($urandom_range(0, 99) < 95)
                    val = value_pool[$urandom_range(0, 7)];
                else
                begin
                    val = $urandom();
                    if ($urandom_range(0, 1) == 0)
                        value_pool[$urandom_range(4, 7)] = val;
                end
                pos = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(1, 33));
                add_op(opcode, val, pos, (k == 0) && wait_first);
                sent++;
            end
            wait_first = ($urandom_range(0, 4) == 0);
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("ordered_list_store test passed");
        else
            $display("ordered_list_store test failed");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, expected_rsp_q.size());
        $display("ordered_list_store test failed");
        $finish;
    end

endmodule
